/* rtl/core/pfd_pkg.sv */
// ============================================================================
// pfd_pkg
// Shared widths, register indexes, microcode program and conversion helpers
// for the filtered-derivative PID controller.
// ============================================================================
package pfd_pkg;

    // Field and datapath widths.
    localparam int CODE_W     = 10;
    localparam int VOLT_W     = 15;
    localparam int ERR_W      = 16;
    localparam int DERR_W     = 17;
    localparam int GAIN_W     = 24;
    localparam int SMOOTH_W   = 16;
    localparam int LIMIT_W    = 15;
    localparam int ACC_W      = 32;
    localparam int CTL_W      = 16;
    localparam int DUTY_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int STEP_W     = 4;

    // Shared multiplier: signed A times a gain extended by a sign bit.
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RND_W   = 34;   // product rounded and shifted by 8
    localparam int SUM_W   = 36;   // headroom for saturating sums

    localparam int GAIN_SHIFT   = 8;
    localparam int SMOOTH_SHIFT = 16;

    // Converter full scale and the PWM offset of 127.5 in half steps.
    localparam int FULL_SCALE = 1023;
    localparam int HALF_SCALE = 511;
    localparam int FRAC_BITS  = 12;
    localparam int DUTY_OFS   = 255 << FRAC_BITS;
    localparam int DUTY_MAX   = 255;

    localparam logic [SUM_W-1:0] ACC_MAX = SUM_W'(64'sd2147483647);
    localparam logic [SUM_W-1:0] ACC_MIN = SUM_W'(-64'sd2147483648);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_DERIV_GAIN  = 3'd2,
        CFG_DERIV_SMOOTH = 3'd3,
        CFG_DRIVE_LIMIT = 3'd4
    } t_cfg_idx;

    // Datapath operations selected by the control word.
    typedef enum logic [3:0] {
        OP_IDLE  = 4'd0,
        OP_CONV  = 4'd1,
        OP_MUL_P = 4'd2,
        OP_MUL_I = 4'd3,
        OP_MUL_D = 4'd4,
        OP_DSUM  = 4'd5,
        OP_MUL_S = 4'd6,
        OP_DUPD  = 4'd7,
        OP_CTL   = 4'd8,
        OP_DUTY  = 4'd9,
        OP_OPEN  = 4'd10,
        OP_EMIT  = 4'd11
    } t_op;

    // Sequencing condition of a control word.
    typedef enum logic [2:0] {
        COND_NEXT = 3'd0,
        COND_IN   = 3'd1,
        COND_OPEN = 3'd2,
        COND_JUMP = 3'd3,
        COND_OUT  = 3'd4
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Program addresses.
    localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CONV  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MUL_P = 4'd2;
    localparam logic [STEP_W-1:0] STEP_MUL_I = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MUL_D = 4'd4;
    localparam logic [STEP_W-1:0] STEP_DSUM  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MUL_S = 4'd6;
    localparam logic [STEP_W-1:0] STEP_DUPD  = 4'd7;
    localparam logic [STEP_W-1:0] STEP_CTL   = 4'd8;
    localparam logic [STEP_W-1:0] STEP_DUTY  = 4'd9;
    localparam logic [STEP_W-1:0] STEP_OPEN  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd11;

    // Microcode ROM: one control word per step.
    function automatic t_uword ucode_rom(input logic [STEP_W-1:0] step);
        t_uword w;
        case (step)
            STEP_IDLE:  w = '{OP_IDLE,  COND_IN,   STEP_CONV};
            STEP_CONV:  w = '{OP_CONV,  COND_OPEN, STEP_OPEN};
            STEP_MUL_P: w = '{OP_MUL_P, COND_NEXT, STEP_IDLE};
            STEP_MUL_I: w = '{OP_MUL_I, COND_NEXT, STEP_IDLE};
            STEP_MUL_D: w = '{OP_MUL_D, COND_NEXT, STEP_IDLE};
            STEP_DSUM:  w = '{OP_DSUM,  COND_NEXT, STEP_IDLE};
            STEP_MUL_S: w = '{OP_MUL_S, COND_NEXT, STEP_IDLE};
            STEP_DUPD:  w = '{OP_DUPD,  COND_NEXT, STEP_IDLE};
            STEP_CTL:   w = '{OP_CTL,   COND_NEXT, STEP_IDLE};
            STEP_DUTY:  w = '{OP_DUTY,  COND_JUMP, STEP_EMIT};
            STEP_OPEN:  w = '{OP_OPEN,  COND_NEXT, STEP_IDLE};
            STEP_EMIT:  w = '{OP_EMIT,  COND_OUT,  STEP_IDLE};
            default:    w = '{OP_IDLE,  COND_JUMP, STEP_IDLE};
        endcase
        return w;
    endfunction

    // round(code * 5 * 2^12 / 1023). Since 20480 = 20*1023 + 20, this is
    // 20*code plus floor((20*code + 511) / 1023), a quotient of at most 20.
    function automatic logic [VOLT_W-1:0] code_to_volts(input logic [CODE_W-1:0] code);
        logic [VOLT_W-1:0] x20;
        logic [VOLT_W-1:0] x;
        logic [4:0]        q0;
        logic [10:0]       r;
        logic              q1;
        x20 = VOLT_W'({code, 4'b0}) + VOLT_W'({code, 2'b0});
        x   = x20 + VOLT_W'(HALF_SCALE);
        q0  = x[VOLT_W-1:10];
        r   = {1'b0, x[9:0]} + 11'(q0);
        q1  = (r >= 11'(FULL_SCALE));
        return x20 + VOLT_W'(q0) + VOLT_W'(q1);
    endfunction

    // floor(code * 255 / 1023) with one correction step on the remainder.
    function automatic logic [DUTY_W-1:0] open_duty(input logic [CODE_W-1:0] code);
        logic [17:0] y;
        logic [7:0]  q0;
        logic [10:0] r;
        y  = {code, 8'b0} - 18'(code);
        q0 = y[17:10];
        r  = {1'b0, y[9:0]} + 11'(q0);
        return q0 + DUTY_W'(r >= 11'(FULL_SCALE));
    endfunction

    // floor((ctl*102 + 255*2^12) / 2^13), limited to 0..255.
    function automatic logic [DUTY_W-1:0] closed_duty(input logic signed [CTL_W-1:0] ctl);
        logic signed [24:0] c;
        logic signed [24:0] num;
        logic [DUTY_W-1:0]  d;
        c   = 25'(ctl);
        num = (c <<< 6) + (c <<< 5) + (c <<< 2) + (c <<< 1) + 25'(DUTY_OFS);
        if (num[24]) begin
            d = '0;
        end else if (num[23:FRAC_BITS+1] > 11'(DUTY_MAX)) begin
            d = DUTY_W'(DUTY_MAX);
        end else begin
            d = num[FRAC_BITS+DUTY_W:FRAC_BITS+1];
        end
        return d;
    endfunction

    // Saturate a wide signed sum to the 32-bit accumulator range.
    function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
        logic signed [ACC_W-1:0] y;
        if (x > $signed(ACC_MAX)) begin
            y = ACC_MAX[ACC_W-1:0];
        end else if (x < $signed(ACC_MIN)) begin
            y = ACC_MIN[ACC_W-1:0];
        end else begin
            y = x[ACC_W-1:0];
        end
        return y;
    endfunction

endpackage

/* rtl/core/pid_filtered_derivative.sv */
// ============================================================================
// pid_filtered_derivative
// Fixed-point PID controller with a first-order filtered derivative, run by
// a microcoded sequencer around one shared multiplier.
// ============================================================================
//
//  Channel   Direction  Contents (lowest bits first)
//  --------  ---------  --------------------------------------------------------
//  s_axis    in         tdata: setpoint_code[9:0], measured_code[19:10]; tuser: open_loop
//  m_axis    out        tdata: pwm_duty[7:0], control_value[23:8],
//                              setpoint_volts[38:24], measured_volts[53:39]
//  cfg       in         i_cfg_we, i_cfg_addr (register index), i_cfg_wdata
//
// A new transaction is accepted only after the last has left its emit step;
// an open-loop one skips the multiplier steps. The closed-loop length is set
// by the single 33x25 multiplier, which serves the P, I, D and smoothing
// products in turn, each followed by a register. Reset (synchronous, active
// low) restores the register defaults and clears the controller history. A
// result waiting on m_axis does not block acceptance; only the final write of
// the next result holds until the output register is free.
// ============================================================================
module pid_filtered_derivative (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration write port.
    input  logic                              i_cfg_we,
    input  logic [pfd_pkg::CFG_IDX_W-1:0]     i_cfg_addr,
    input  logic [pfd_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    // Input stream.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [23:0]                       s_axis_tdata,  // setpoint_code, measured_code
    input  logic                              s_axis_tuser,  // open_loop
    // Output stream.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [55:0]                       m_axis_tdata   // pwm_duty, control_value,
                                                             // setpoint_volts, measured_volts
);
    import pfd_pkg::*;

    // Configuration registers.
    logic [GAIN_W-1:0]   r_kp, r_ki, r_kd;
    logic [SMOOTH_W-1:0] r_sm;
    logic [LIMIT_W-1:0]  r_lim;

    // Sequencer.
    logic [STEP_W-1:0] r_step, n_step;
    t_uword            w_uw;

    // Captured transaction.
    logic [CODE_W-1:0] r_sp_code, r_mv_code;
    logic              r_open;

    // Datapath registers.
    logic [VOLT_W-1:0]        r_sp, r_mv;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [DERR_W-1:0] r_de;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [RND_W-1:0]  r_p;
    logic signed [ACC_W-1:0]  r_s;
    logic signed [CTL_W-1:0]  r_ctl;
    logic [DUTY_W-1:0]        r_duty;

    // Controller history.
    logic signed [ERR_W-1:0] r_prev;
    logic signed [ACC_W-1:0] r_i, r_d;
    logic signed [CTL_W-1:0] r_last;

    // Output register.
    logic                    r_o_valid;
    logic [DUTY_W-1:0]       r_o_duty;
    logic signed [CTL_W-1:0] r_o_ctl;
    logic [VOLT_W-1:0]       r_o_sp, r_o_mv;

    logic                     w_in_acc;
    logic                     w_emit;
    logic [VOLT_W-1:0]        w_sp, w_mv;
    logic signed [ERR_W-1:0]  w_err;
    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_rnd8_t, w_rnd16_t;
    logic signed [RND_W-1:0]  w_rnd8;
    logic signed [ACC_W-1:0]  w_rnd16;
    logic [DERR_W-1:0]        w_last_abs;
    logic                     w_int_en;
    logic signed [SUM_W-1:0]  w_sum, w_lim_s;
    logic signed [CTL_W-1:0]  w_ctl;

    assign w_uw = ucode_rom(r_step);

    assign s_axis_tready = (r_step == STEP_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_emit        = (w_uw.op == OP_EMIT) && (!r_o_valid || m_axis_tready);

    // Step sequencing.
    always_comb begin
        case (w_uw.cond)
            COND_NEXT: n_step = r_step + STEP_W'(1);
            COND_IN:   n_step = w_in_acc ? w_uw.target : r_step;
            COND_OPEN: n_step = r_open ? w_uw.target : r_step + STEP_W'(1);
            COND_JUMP: n_step = w_uw.target;
            COND_OUT:  n_step = w_emit ? w_uw.target : r_step;
            default:   n_step = STEP_IDLE;
        endcase
    end

    // Code conversion and error.
    assign w_sp  = code_to_volts(r_sp_code);
    assign w_mv  = code_to_volts(r_mv_code);
    assign w_err = $signed({1'b0, w_sp}) - $signed({1'b0, w_mv});

    // Shared multiplier operand selection; the gains are always non-negative.
    always_comb begin
        case (w_uw.op)
            OP_MUL_P: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = $signed({1'b0, r_kp});
            end
            OP_MUL_I: begin
                w_mul_a = MUL_A_W'(r_err);
                w_mul_b = $signed({1'b0, r_ki});
            end
            OP_MUL_D: begin
                w_mul_a = MUL_A_W'(r_de);
                w_mul_b = $signed({1'b0, r_kd});
            end
            OP_MUL_S: begin
                w_mul_a = MUL_A_W'(r_s);
                w_mul_b = $signed({9'b0, r_sm});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // Round half up, then shift: arithmetic shift of the biased product.
    assign w_rnd8_t  = r_prod + PROD_W'(1 << (GAIN_SHIFT - 1));
    assign w_rnd8    = w_rnd8_t[RND_W+GAIN_SHIFT-1:GAIN_SHIFT];
    assign w_rnd16_t = r_prod + PROD_W'(1 << (SMOOTH_SHIFT - 1));
    assign w_rnd16   = w_rnd16_t[ACC_W+SMOOTH_SHIFT-1:SMOOTH_SHIFT];

    // The integral advances only while the previous output was inside the limit.
    assign w_last_abs = r_last[CTL_W-1] ? (DERR_W'(0) - DERR_W'(r_last))
                                        : DERR_W'(r_last);
    assign w_int_en   = (w_last_abs < DERR_W'(r_lim));

    // Output sum and clamp.
    assign w_sum   = SUM_W'(r_p) + SUM_W'(r_i) + SUM_W'(r_d);
    assign w_lim_s = $signed({{(SUM_W-LIMIT_W){1'b0}}, r_lim});
    always_comb begin
        if (w_sum > w_lim_s) begin
            w_ctl = w_lim_s[CTL_W-1:0];
        end else if (w_sum < -w_lim_s) begin
            w_ctl = CTL_W'(-w_lim_s);
        end else begin
            w_ctl = w_sum[CTL_W-1:0];
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= STEP_IDLE;
            r_o_valid <= 1'b0;
            r_prev    <= '0;
            r_i       <= '0;
            r_d       <= '0;
            r_last    <= '0;
            r_kp      <= GAIN_W'(256);
            r_ki      <= GAIN_W'(51);
            r_kd      <= GAIN_W'(768000);
            r_sm      <= SMOOTH_W'(649);
            r_lim     <= LIMIT_W'(10240);
        end else begin
            r_step <= n_step;

            if (w_emit) begin
                r_o_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end

            if (w_uw.op == OP_CONV) begin
                r_prev <= w_err;
            end
            if (w_uw.op == OP_MUL_D && w_int_en) begin
                r_i <= sat_acc(SUM_W'(r_i) + SUM_W'(w_rnd8));
            end
            if (w_uw.op == OP_DUPD) begin
                r_d <= w_rnd16;
            end
            if (w_uw.op == OP_CTL) begin
                r_last <= w_ctl;
            end

            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_PROP_GAIN:    r_kp  <= i_cfg_wdata;
                    CFG_INTEG_GAIN:   r_ki  <= i_cfg_wdata;
                    CFG_DERIV_GAIN:   r_kd  <= i_cfg_wdata;
                    CFG_DERIV_SMOOTH: r_sm  <= i_cfg_wdata[SMOOTH_W-1:0];
                    CFG_DRIVE_LIMIT:  r_lim <= i_cfg_wdata[LIMIT_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sp_code <= s_axis_tdata[CODE_W-1:0];
            r_mv_code <= s_axis_tdata[2*CODE_W-1:CODE_W];
            r_open    <= s_axis_tuser;
        end

        case (w_uw.op)
            OP_CONV: begin
                r_sp  <= w_sp;
                r_mv  <= w_mv;
                r_err <= w_err;
                r_de  <= DERR_W'(w_err) - DERR_W'(r_prev);
            end
            OP_MUL_P: r_prod <= w_prod;
            OP_MUL_I: begin
                r_p    <= w_rnd8;
                r_prod <= w_prod;
            end
            OP_MUL_D: r_prod <= w_prod;
            OP_DSUM:  r_s    <= sat_acc(SUM_W'(w_rnd8) + SUM_W'(r_d));
            OP_MUL_S: r_prod <= w_prod;
            OP_CTL:   r_ctl  <= w_ctl;
            OP_DUTY:  r_duty <= closed_duty(r_ctl);
            OP_OPEN: begin
                r_duty <= open_duty(r_sp_code);
                r_ctl  <= '0;
            end
            default: begin
            end
        endcase

        if (w_emit) begin
            r_o_duty <= r_duty;
            r_o_ctl  <= r_ctl;
            r_o_sp   <= r_sp;
            r_o_mv   <= r_mv;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {2'b0, r_o_mv, r_o_sp, r_o_ctl, r_o_duty};

    // A delivered control value never leaves the configured clamp.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> ($signed(r_o_ctl) <= $signed({1'b0, r_lim})) &&
                      ($signed(r_o_ctl) >= -$signed({1'b0, r_lim})))
        else $error("control value outside drive limit");

    // An accepted transaction starts the program at the conversion step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_step == STEP_CONV) && !s_axis_tready)
        else $error("sequencer did not start after acceptance");

    // A new result appears only from the emit step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_step) == STEP_EMIT)
        else $error("output valid rose outside the emit step");

endmodule
